/* hdl/grid_reach_zone_bfs_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros used by the checker of the grid reach zone block.
// ----------------------------------------------------------------------------
`ifndef GRID_REACH_ZONE_BFS_MACROS_SVH
`define GRID_REACH_ZONE_BFS_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GRZB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GRZB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/grzb_pkg.sv */
// ----------------------------------------------------------------------------
// grzb_pkg
// Types and constants of the grid reach zone block and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package grzb_pkg;

	// Operation codes of a command transaction.
	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_COMPUTE = 2'd1;
	localparam logic [1:0] OP_QUERY   = 2'd2;
	localparam logic [1:0] OP_RSVD    = 2'd3;

	// Configuration port.
	localparam int CFG_AW = 1;
	localparam int CFG_DW = 6;
	localparam logic [CFG_AW-1:0] REG_COLS_USED = 1'd0;
	localparam logic [CFG_AW-1:0] REG_ROWS_USED = 1'd1;
	localparam logic [5:0] COLS_RESET = 6'd20;
	localparam logic [4:0] ROWS_RESET = 5'd15;

	// Largest value the count field can show.
	localparam logic [9:0] CNT_MAX = 10'd1023;

	// Walk directions in order: up, down, left, right.
	localparam logic signed [1:0] STEP_DX [4] = '{2'sd0, 2'sd0, -2'sd1, 2'sd1};
	localparam logic signed [1:0] STEP_DY [4] = '{-2'sd1, 2'sd1, 2'sd0, 2'sd0};

	typedef struct packed {
		logic [1:0] op;
		logic [4:0] cell_x;
		logic [3:0] cell_y;
		logic       blocked;
		logic [5:0] move_range;
	} cmd_t;

	typedef struct packed {
		logic       in_zone;
		logic [9:0] reachable_count;
		logic       bad_cell;
	} rsp_t;

endpackage

/* hdl/grid_reach_zone_bfs.sv */
// ----------------------------------------------------------------------------
// grid_reach_zone_bfs
// Range-limited four-connected flood fill over an obstacle grid.
// ----------------------------------------------------------------------------
// A command transaction is taken at a rising edge with start high and busy
// low. Its fields select an obstacle write, a zone compute from a start cell,
// or a query of one reach bit. Every command returns exactly one response on
// rsp, marked by done for a single cycle; the receiver cannot stall it, so
// the response must be taken in that cycle.
// A write, a command with an out-of-grid coordinate and the reserved op code
// answer in the cycle after acceptance and leave busy low. A query reads the
// reach row first and answers from state S_QRD. A compute clears the reach map
// one row per cycle, marks the start cell, then walks the queue: each dequeued
// cell takes one pop, four neighbor checks and one drain, or only the pop and
// one check when it sits at the range limit, and a final empty pop answers.
// Each bitmap has a single read port, so one neighbor is looked up per cycle.
// After reset the block sweeps both bitmaps clear, one row per cycle, with busy
// high. Configuration writes are taken at any time, including during that
// sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_reach_zone_bfs #(
	parameter int GRID_COLS = 32,
	parameter int GRID_ROWS = 16,
	parameter int MAX_RANGE = 63
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  grzb_pkg::cmd_t                cmd,
	output logic                          done,
	output grzb_pkg::rsp_t                rsp,
	input  logic                          cfg_we,
	input  logic [grzb_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [grzb_pkg::CFG_DW-1:0]   cfg_wdata
);
	import grzb_pkg::*;

	localparam int CELLS = GRID_COLS * GRID_ROWS;
	localparam int XW    = $clog2(GRID_COLS);
	localparam int YW    = $clog2(GRID_ROWS);
	localparam int AW    = $clog2(CELLS);
	localparam int QW    = AW + 1;
	localparam int RW    = $clog2(MAX_RANGE + 1);
	localparam int CW    = $clog2(CELLS + 1);

	// One walk queue entry: the cell and its distance from the start.
	typedef struct packed {
		logic [XW-1:0] x;
		logic [YW-1:0] y;
		logic [RW-1:0] cost;
	} qent_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_QRD,
		S_ZCLR,
		S_ZSTART,
		S_POP,
		S_NB,
		S_CHK
	} state_t;

	// Sequencer and configuration registers.
	state_t        state_q;
	logic [YW-1:0] clr_q;
	logic [5:0]    cols_q;
	logic [4:0]    rows_q;
	logic [XW-1:0] sx_q;
	logic [YW-1:0] sy_q;
	logic [RW-1:0] range_q;
	logic [XW-1:0] qx_q;
	logic [QW-1:0] head_q;
	logic [QW-1:0] tail_q;
	logic [CW-1:0] marked_q;
	logic [1:0]    dir_q;
	qent_t         cur_q;
	logic          done_q;
	rsp_t          rsp_q;

	// Neighbor lookup stage: the cell whose bitmap rows are being read.
	logic          nb_ok_s1;
	logic [XW-1:0] nb_x_s1;
	logic [YW-1:0] nb_y_s1;

	// Bitmaps are stored one row per word; the queue one entry per word.
	logic [GRID_COLS-1:0] obst_mem  [GRID_ROWS];
	logic [GRID_COLS-1:0] reach_mem [GRID_ROWS];
	qent_t                q_mem     [CELLS];
	logic [GRID_COLS-1:0] obst_row_q;
	logic [GRID_COLS-1:0] reach_row_q;
	qent_t                q_rd_q;

	// Memory port controls.
	logic          obst_we, obst_clr, obst_bit;
	logic [YW-1:0] obst_row;
	logic [XW-1:0] obst_col;
	logic          reach_we, reach_clr;
	logic [YW-1:0] reach_row;
	logic [XW-1:0] reach_col;
	logic [YW-1:0] rd_row;
	logic          q_we;
	logic [AW-1:0] q_wa, q_ra;
	qent_t         q_wd;

	// Datapath signals.
	logic [7:0]    cols_lim, rows_lim;
	logic          cmd_ok;
	qent_t         cur;
	logic [8:0]    nx_w, ny_w;
	logic          nb_in;
	logic          cost_stop;
	logic          push;
	logic [9:0]    cnt_out;
	logic [RW-1:0] range_in;

	// Registers above the grid size act as the grid size.
	assign cols_lim = (8'(cols_q) > 8'(GRID_COLS)) ? 8'(GRID_COLS) : 8'(cols_q);
	assign rows_lim = (8'(rows_q) > 8'(GRID_ROWS)) ? 8'(GRID_ROWS) : 8'(rows_q);
	assign cmd_ok   = (8'(cmd.cell_x) < cols_lim) && (8'(cmd.cell_y) < rows_lim);
	assign range_in = (8'(cmd.move_range) > 8'(MAX_RANGE)) ? RW'(MAX_RANGE)
	                                                        : RW'(cmd.move_range);

	// The entry being expanded comes straight from the queue read register on
	// the first direction and from its saved copy afterwards.
	assign cur  = (dir_q == 2'd0) ? q_rd_q : cur_q;
	// A step off the left or top edge wraps to a large value, so one unsigned
	// compare per axis covers both edges.
	assign nx_w  = 9'(cur.x) + 9'(STEP_DX[dir_q]);
	assign ny_w  = 9'(cur.y) + 9'(STEP_DY[dir_q]);
	assign nb_in = (nx_w < 9'(cols_lim)) && (ny_w < 9'(rows_lim));
	assign cost_stop = (q_rd_q.cost >= range_q);

	// The neighbor looked up in the previous cycle is entered if it is open
	// and not yet marked.
	assign push = nb_ok_s1 && !obst_row_q[nb_x_s1] && !reach_row_q[nb_x_s1]
	              && ((state_q == S_NB) || (state_q == S_CHK));

	assign cnt_out = (16'(marked_q) > 16'(CNT_MAX)) ? CNT_MAX : 10'(marked_q);

	always_comb begin
		obst_we   = 1'b0;
		obst_clr  = 1'b0;
		obst_bit  = 1'b0;
		obst_row  = clr_q;
		obst_col  = '0;
		reach_we  = 1'b0;
		reach_clr = 1'b0;
		reach_row = clr_q;
		reach_col = '0;
		rd_row    = '0;
		q_we      = 1'b0;
		q_wa      = tail_q[AW-1:0];
		q_ra      = head_q[AW-1:0];
		q_wd      = '{x: nb_x_s1, y: nb_y_s1, cost: RW'(cur_q.cost + 1'b1)};
		case (state_q)
			S_INIT: begin
				obst_we   = 1'b1;
				obst_clr  = 1'b1;
				reach_we  = 1'b1;
				reach_clr = 1'b1;
			end
			S_IDLE: begin
				rd_row = YW'(cmd.cell_y);
				if (start && cmd_ok && (cmd.op == OP_WRITE)) begin
					obst_we  = 1'b1;
					obst_row = YW'(cmd.cell_y);
					obst_col = XW'(cmd.cell_x);
					obst_bit = cmd.blocked;
				end
			end
			S_ZCLR: begin
				reach_we  = 1'b1;
				reach_clr = 1'b1;
			end
			S_ZSTART: begin
				reach_we  = 1'b1;
				reach_row = sy_q;
				reach_col = sx_q;
				q_we      = 1'b1;
				q_wa      = '0;
				q_wd      = '{x: sx_q, y: sy_q, cost: '0};
			end
			S_NB, S_CHK: begin
				rd_row = ny_w[YW-1:0];
				if (push) begin
					reach_we  = 1'b1;
					reach_row = nb_y_s1;
					reach_col = nb_x_s1;
					q_we      = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Bitmap and queue storage: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (obst_we) begin
			if (obst_clr) begin
				obst_mem[obst_row] <= '0;
			end else begin
				obst_mem[obst_row][obst_col] <= obst_bit;
			end
		end
		if (reach_we) begin
			if (reach_clr) begin
				reach_mem[reach_row] <= '0;
			end else begin
				reach_mem[reach_row][reach_col] <= 1'b1;
			end
		end
		obst_row_q  <= obst_mem[rd_row];
		reach_row_q <= reach_mem[rd_row];
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			q_mem[q_wa] <= q_wd;
		end
		q_rd_q <= q_mem[q_ra];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			clr_q    <= '0;
			cols_q   <= COLS_RESET;
			rows_q   <= ROWS_RESET;
			head_q   <= '0;
			tail_q   <= '0;
			marked_q <= '0;
			dir_q    <= '0;
			nb_ok_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			nb_ok_s1 <= 1'b0;
			if (cfg_we) begin
				if (cfg_addr == REG_COLS_USED) begin
					cols_q <= cfg_wdata;
				end else begin
					rows_q <= cfg_wdata[4:0];
				end
			end
			case (state_q)
				S_INIT: begin
					if (clr_q == YW'(GRID_ROWS - 1)) begin
						clr_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (start) begin
						if (cmd_ok && (cmd.op == OP_COMPUTE)) begin
							sx_q    <= XW'(cmd.cell_x);
							sy_q    <= YW'(cmd.cell_y);
							range_q <= range_in;
							clr_q   <= '0;
							state_q <= S_ZCLR;
						end else if (cmd_ok && (cmd.op == OP_QUERY)) begin
							qx_q    <= XW'(cmd.cell_x);
							state_q <= S_QRD;
						end else begin
							// Writes, flagged coordinates and the reserved code.
							done_q <= 1'b1;
							rsp_q  <= '{in_zone: 1'b0, reachable_count: cnt_out,
							            bad_cell: !cmd_ok && (cmd.op != OP_RSVD)};
						end
					end
				end
				S_QRD: begin
					done_q  <= 1'b1;
					rsp_q   <= '{in_zone: reach_row_q[qx_q], reachable_count: cnt_out,
					             bad_cell: 1'b0};
					state_q <= S_IDLE;
				end
				S_ZCLR: begin
					if (clr_q == YW'(GRID_ROWS - 1)) begin
						clr_q   <= '0;
						state_q <= S_ZSTART;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				S_ZSTART: begin
					head_q   <= '0;
					tail_q   <= QW'(1);
					marked_q <= CW'(1);
					state_q  <= S_POP;
				end
				S_POP: begin
					if (head_q == tail_q) begin
						done_q  <= 1'b1;
						rsp_q   <= '{in_zone: 1'b1, reachable_count: cnt_out,
						             bad_cell: 1'b0};
						state_q <= S_IDLE;
					end else begin
						head_q  <= head_q + 1'b1;
						dir_q   <= '0;
						state_q <= S_NB;
					end
				end
				S_NB: begin
					if ((dir_q == 2'd0) && cost_stop) begin
						// Cell lies at the range limit: nothing to expand.
						state_q <= S_POP;
					end else begin
						if (dir_q == 2'd0) begin
							cur_q <= q_rd_q;
						end
						nb_ok_s1 <= nb_in;
						nb_x_s1  <= nx_w[XW-1:0];
						nb_y_s1  <= ny_w[YW-1:0];
						if (push) begin
							tail_q   <= tail_q + 1'b1;
							marked_q <= marked_q + 1'b1;
						end
						dir_q <= dir_q + 1'b1;
						if (dir_q == 2'd3) begin
							state_q <= S_CHK;
						end
					end
				end
				S_CHK: begin
					if (push) begin
						tail_q   <= tail_q + 1'b1;
						marked_q <= marked_q + 1'b1;
					end
					state_q <= S_POP;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

/* hdl/grzb_checker.sv */
// ----------------------------------------------------------------------------
// grzb_checker
// Port-level checks of the grid reach zone block, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "grid_reach_zone_bfs_macros.svh"

module grzb_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input grzb_pkg::cmd_t cmd,
	input logic           done,
	input grzb_pkg::rsp_t rsp
);
	import grzb_pkg::*;

	logic acc;
	assign acc = start && !busy;

	// An obstacle write answers in the next cycle, never inside the zone.
	`GRZB_ASSERT_NEXT(a_write_resp, clk, arst_n, acc && (cmd.op == OP_WRITE), done && !rsp.in_zone, "write transaction did not answer in one cycle")
	// A query either answers at once (flagged) or holds busy for one lookup.
	`GRZB_ASSERT_NEXT(a_query_step, clk, arst_n, acc && (cmd.op == OP_QUERY), busy ^ done, "query transaction took an unexpected path")
	// A flagged coordinate is never reported as reachable.
	`GRZB_ASSERT_SAME(a_bad_zone, clk, arst_n, done && rsp.bad_cell, !rsp.in_zone, "flagged transaction reported in zone")
	// A reached cell implies a compute marked at least one cell.
	`GRZB_ASSERT_SAME(a_zone_count, clk, arst_n, done && rsp.in_zone, rsp.reachable_count != 10'd0, "reached cell with zero count")

endmodule

bind grid_reach_zone_bfs grzb_checker u_grzb_checker (.*);
